/* rtl/tlvd_pkg.sv */
// Shared types and constants for the TLV record deframer.
package tlvd_pkg;

  // Parser phase codes.
  localparam logic [2:0] PH_TYPE_HI = 3'd0;
  localparam logic [2:0] PH_TYPE_LO = 3'd1;
  localparam logic [2:0] PH_LEN_HI  = 3'd2;
  localparam logic [2:0] PH_LEN_LO  = 3'd3;
  localparam logic [2:0] PH_VALUE   = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_QUIRK_ENABLE = 2'd0;
  localparam logic [1:0] CFG_QUIRK_TYPE   = 2'd1;
  localparam logic [1:0] CFG_QUIRK_LENGTH = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;

  // Configuration reset values.
  localparam logic        QUIRK_ENABLE_RST = 1'b1;
  localparam logic [15:0] QUIRK_TYPE_RST   = 16'h0013;
  localparam logic [15:0] QUIRK_LENGTH_RST = 16'h0002;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        buffer_start;
    logic [15:0] buffer_length;
  } in_word_t;

  typedef struct packed {
    logic [15:0] record_type;
    logic [15:0] record_length;
    logic [7:0]  value_byte;
    logic [15:0] value_index;
    logic        empty_record;
    logic        record_end;
  } out_word_t;

  typedef struct packed {
    logic        quirk_enable;
    logic [15:0] quirk_type;
    logic [15:0] quirk_length;
  } cfg_t;

  // Result of one parse step toward the output register.
  typedef struct packed {
    logic      valid;
    out_word_t word;
  } result_t;

endpackage

/* rtl/tlvd_stream_if.sv */
// Valid/ready stream channel carrying one word of a given payload type.
interface tlvd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tlvd_parser.sv */
// Parser state and the per-byte step logic of the TLV deframer.
module tlvd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  tlvd_pkg::in_word_t item,
  input  tlvd_pkg::cfg_t     cfg,
  output tlvd_pkg::result_t  result
);
  import tlvd_pkg::*;

  logic [2:0]  phase;
  logic [15:0] position;
  logic [15:0] held_type;
  logic [15:0] held_length;
  logic [15:0] bytes_left;
  logic [7:0]  held_length_high;

  logic [2:0]  phase_next;
  logic [15:0] position_next;
  logic [15:0] held_type_next;
  logic [15:0] held_length_next;
  logic [15:0] bytes_left_next;
  logic [7:0]  held_length_high_next;

  logic [2:0]  ph_cur;
  logic [15:0] pos_cur;
  logic [15:0] left_cur;
  logic        in_range;
  logic [15:0] len_word;
  logic [17:0] rec_end_pos;
  logic        too_long;
  logic        quirk_hit;

  // A buffer start rewinds the position and abandons any record in progress.
  assign ph_cur   = item.buffer_start ? PH_TYPE_HI : phase;
  assign pos_cur  = item.buffer_start ? 16'd0 : position;
  assign left_cur = item.buffer_start ? 16'd0 : bytes_left;
  assign in_range = pos_cur < item.buffer_length;

  // Record fit and quirk checks made on the low length byte.
  assign len_word    = {held_length_high, item.data_byte};
  assign rec_end_pos = {2'b00, pos_cur} + 18'd1 + {2'b00, len_word};
  assign too_long    = rec_end_pos > {2'b00, item.buffer_length};
  assign quirk_hit   = cfg.quirk_enable && (held_type == cfg.quirk_type) &&
                       (len_word != cfg.quirk_length);

  // Next state and the result word for the byte at the input.
  always_comb begin
    phase_next            = ph_cur;
    position_next         = pos_cur;
    held_type_next        = held_type;
    held_length_next      = held_length;
    bytes_left_next       = left_cur;
    held_length_high_next = held_length_high;
    result.valid              = 1'b0;
    result.word.record_type   = held_type;
    result.word.record_length = held_length;
    result.word.value_byte    = 8'd0;
    result.word.value_index   = 16'd0;
    result.word.empty_record  = 1'b0;
    result.word.record_end    = 1'b0;
    if (in_range) begin
      position_next = pos_cur + 16'd1;
      case (ph_cur)
        PH_TYPE_HI: begin
          held_type_next = {item.data_byte, 8'd0};
          phase_next     = PH_TYPE_LO;
        end
        PH_TYPE_LO: begin
          held_type_next = {held_type[15:8], item.data_byte};
          phase_next     = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          held_length_high_next = item.data_byte;
          phase_next            = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          held_length_next          = len_word;
          result.word.record_length = len_word;
          phase_next                = PH_TYPE_HI;
          if (!too_long) begin
            if (quirk_hit) begin
              if (cfg.quirk_length != 16'd0) begin
                bytes_left_next = cfg.quirk_length;
                phase_next      = PH_SKIP;
              end
            end else if (len_word == 16'd0) begin
              result.valid             = 1'b1;
              result.word.empty_record = 1'b1;
              result.word.record_end   = 1'b1;
            end else begin
              bytes_left_next = len_word;
              phase_next      = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          result.valid            = 1'b1;
          result.word.value_byte  = item.data_byte;
          result.word.value_index = held_length - left_cur;
          result.word.record_end  = (left_cur == 16'd1);
          bytes_left_next         = left_cur - 16'd1;
          if (left_cur == 16'd1) begin
            phase_next = PH_TYPE_HI;
          end
        end
        PH_SKIP: begin
          bytes_left_next = left_cur - 16'd1;
          if (left_cur == 16'd1) begin
            phase_next = PH_TYPE_HI;
          end
        end
        default: begin
          phase_next = PH_TYPE_HI;
        end
      endcase
    end
  end

  // Running state advances on every accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_TYPE_HI;
      position         <= 16'd0;
      held_type        <= 16'd0;
      held_length      <= 16'd0;
      bytes_left       <= 16'd0;
      held_length_high <= 8'd0;
    end else if (accept) begin
      phase            <= phase_next;
      position         <= position_next;
      held_type        <= held_type_next;
      held_length      <= held_length_next;
      bytes_left       <= bytes_left_next;
      held_length_high <= held_length_high_next;
    end
  end

`ifndef ASSERT_OFF
  // Header phases never carry a pending value or skip count.
  a_hdr_no_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_TYPE_HI || phase == PH_TYPE_LO || phase == PH_LEN_HI ||
     phase == PH_LEN_LO) |-> (bytes_left == 16'd0))
    else $error("bytes_left nonzero in a header phase");

  // Value and skip phases always have bytes still to come.
  a_body_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_VALUE || phase == PH_SKIP) |-> (bytes_left != 16'd0))
    else $error("bytes_left zero in a body phase");

  // A value byte never indexes past its record.
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.word.empty_record) |->
    (result.word.value_index < result.word.record_length))
    else $error("value_index beyond record length");

  // An accepted word past the buffer end leaves the position unchanged.
  a_past_end: assert property (@(posedge clk) disable iff (rst)
    (accept && !item.buffer_start && (position >= item.buffer_length)) |=>
    $stable(position))
    else $error("position moved past buffer end");
`endif

endmodule

/* rtl/tlvd_out_reg.sv */
// Output register that holds one result word until the sink takes it.
module tlvd_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tlvd_pkg::result_t  result,
  output logic               can_load,
  tlvd_stream_if.source      out_ch
);
  import tlvd_pkg::*;

  logic      valid;
  out_word_t word;

  // A new word may enter whenever the register is empty or being drained.
  assign can_load     = !valid || out_ch.ready;
  assign out_ch.valid = valid;
  assign out_ch.data  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= result.valid;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  // Payload carries no reset.
  always_ff @(posedge clk) begin
    if (load && result.valid) begin
      word <= result.word;
    end
  end

endmodule

/* rtl/tlv_record_deframer_unit.sv */
// Top level of the TLV record deframer: configuration registers, parser, output register.
// A result word appears on the output in the cycle after its input byte is accepted.
// Throughput: one input byte per clock; the only stall is a full output register whose
// word the sink does not take, set by the single output register stage.
// Reset (rst, synchronous): parser returns to expecting a type high byte at position zero,
// the output register empties, and the quirk registers return to enable 1, type 0x13, length 2.
module tlv_record_deframer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [tlvd_pkg::CFG_DATA_W-1:0] cfg_data,
  tlvd_stream_if.sink                     in_ch,
  tlvd_stream_if.source                   out_ch
);
  import tlvd_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    accept;
  logic    can_load;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quirk_enable <= QUIRK_ENABLE_RST;
      cfg.quirk_type   <= QUIRK_TYPE_RST;
      cfg.quirk_length <= QUIRK_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUIRK_ENABLE: cfg.quirk_enable <= cfg_data[0];
        CFG_QUIRK_TYPE:   cfg.quirk_type   <= cfg_data;
        CFG_QUIRK_LENGTH: cfg.quirk_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input handshake.
  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  tlvd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_ch.data),
    .cfg    (cfg),
    .result (result)
  );

  tlvd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (result),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

/* tb/tlvd_record_checker.sv */
// Checker for the TLV record deframer: predicts result words and compares them.
`timescale 1ns / 1ps

module tlvd_record_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [tlvd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  tlvd_pkg::in_word_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  tlvd_pkg::out_word_t             out_data,
  output int unsigned                     words_due_count,
  output int unsigned                     mismatch_count
);
  import tlvd_pkg::*;

  // Quirk settings as last written.
  logic        quirk_on;
  logic [15:0] quirk_kind;
  logic [15:0] quirk_len;

  // Parser state of the deframer.
  logic [2:0]  cur_phase;
  logic [15:0] buf_pos;
  logic [15:0] rec_type;
  logic [15:0] rec_len;
  logic [15:0] rec_left;
  logic [7:0]  len_high;

  // Result words predicted but not yet seen, oldest first.
  out_word_t words_due[$];

  // Queue one predicted result word tagged with the current record header.
  task automatic expect_word(logic [7:0] value, logic [15:0] index, logic empty, logic last);
    out_word_t w;
    w.record_type   = rec_type;
    w.record_length = rec_len;
    w.value_byte    = value;
    w.value_index   = index;
    w.empty_record  = empty;
    w.record_end    = last;
    words_due.push_back(w);
  endtask

  // Advance the parser by one accepted input word.
  task automatic deframe_byte(in_word_t w);
    int unsigned here;
    if (w.buffer_start) begin
      buf_pos   = 16'd0;
      cur_phase = PH_TYPE_HI;
      rec_left  = 16'd0;
    end
    // Bytes past the end of the buffer leave the state alone.
    if (buf_pos >= w.buffer_length) return;
    here    = buf_pos;
    buf_pos = buf_pos + 16'd1;
    case (cur_phase)
      PH_TYPE_HI: begin
        rec_type  = {w.data_byte, 8'h00};
        cur_phase = PH_TYPE_LO;
      end
      PH_TYPE_LO: begin
        rec_type[7:0] = w.data_byte;
        cur_phase     = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_high  = w.data_byte;
        cur_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        rec_len   = {len_high, w.data_byte};
        cur_phase = PH_TYPE_HI;
        // A record that overruns the buffer is dropped right after its header.
        if (here + 1 + int'(rec_len) <= int'(w.buffer_length)) begin
          if (quirk_on && rec_type == quirk_kind && rec_len != quirk_len) begin
            if (quirk_len != 16'd0) begin
              rec_left  = quirk_len;
              cur_phase = PH_SKIP;
            end
          end else if (rec_len == 16'd0) begin
            expect_word(8'h00, 16'd0, 1'b1, 1'b1);
          end else begin
            rec_left  = rec_len;
            cur_phase = PH_VALUE;
          end
        end
      end
      PH_VALUE: begin
        expect_word(w.data_byte, rec_len - rec_left, 1'b0, rec_left == 16'd1);
        rec_left = rec_left - 16'd1;
        if (rec_left == 16'd0) cur_phase = PH_TYPE_HI;
      end
      PH_SKIP: begin
        rec_left = rec_left - 16'd1;
        if (rec_left == 16'd0) cur_phase = PH_TYPE_HI;
      end
      default: cur_phase = PH_TYPE_HI;
    endcase
  endtask

  task automatic report_field(string name, logic [15:0] want, logic [15:0] got);
    $display("%0t: %s expected %h, got %h", $time, name, want, got);
    mismatch_count = mismatch_count + 1;
  endtask

  // Compare one accepted result word with the oldest prediction.
  task automatic compare_word(out_word_t got);
    out_word_t want;
    if (words_due.size() == 0) begin
      $display("%0t: unexpected word, expected none, got type %h length %h byte %h index %h",
               $time, got.record_type, got.record_length, got.value_byte, got.value_index);
      mismatch_count = mismatch_count + 1;
      return;
    end
    want = words_due.pop_front();
    if (got.record_type !== want.record_type)
      report_field("record_type", want.record_type, got.record_type);
    if (got.record_length !== want.record_length)
      report_field("record_length", want.record_length, got.record_length);
    if (got.value_byte !== want.value_byte)
      report_field("value_byte", want.value_byte, got.value_byte);
    if (got.value_index !== want.value_index)
      report_field("value_index", want.value_index, got.value_index);
    if (got.empty_record !== want.empty_record)
      report_field("empty_record", want.empty_record, got.empty_record);
    if (got.record_end !== want.record_end)
      report_field("record_end", want.record_end, got.record_end);
  endtask

  // Sample every handshake at the clock edge, predictions before comparisons.
  always @(posedge clk) begin
    if (rst) begin
      quirk_on       = QUIRK_ENABLE_RST;
      quirk_kind     = QUIRK_TYPE_RST;
      quirk_len      = QUIRK_LENGTH_RST;
      cur_phase      = PH_TYPE_HI;
      buf_pos        = 16'd0;
      rec_type       = 16'd0;
      rec_len        = 16'd0;
      rec_left       = 16'd0;
      len_high       = 8'd0;
      mismatch_count = 0;
      words_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUIRK_ENABLE: quirk_on   = cfg_data[0];
          CFG_QUIRK_TYPE:   quirk_kind = cfg_data[15:0];
          CFG_QUIRK_LENGTH: quirk_len  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) deframe_byte(in_data);
      if (out_valid && out_ready) compare_word(out_data);
    end
    words_due_count <= words_due.size();
  end

endmodule

/* tb/tb_tlv_record_deframer_unit.sv */
// Testbench top for the TLV record deframer: stimulus, idling, register phases and verdict.
`timescale 1ns / 1ps

module tb_tlv_record_deframer_unit;
  import tlvd_pkg::*;

  // Idling styles for either side of the block.
  localparam int unsigned IDLE_NONE  = 0;
  localparam int unsigned IDLE_HEAVY = 1;
  localparam int unsigned IDLE_LIGHT = 2;

  // Index with no register behind it.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // Opening buffers: a stream with no buffer start holding an empty record, a
  // one-byte record, a quirk record with the wrong length and a byte past the
  // end; then a buffer with a record too long for it and a cut-off header.
  localparam logic [127:0] OPEN_STREAM = 128'hFFFF_0000_0000_0001_FF00_1300_01AA_555A;
  localparam logic [47:0]  OPEN_SHORT  = 48'h1234_FFFF_ABCD;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tlvd_stream_if #(.payload_t(in_word_t))  in_ch ();
  tlvd_stream_if #(.payload_t(out_word_t)) out_ch ();

  int unsigned words_due_count;
  int unsigned mismatch_count;

  // Quirk settings as written, used to shape well-formed buffers.
  logic        quirk_on   = QUIRK_ENABLE_RST;
  logic [15:0] quirk_kind = QUIRK_TYPE_RST;
  logic [15:0] quirk_len  = QUIRK_LENGTH_RST;

  int unsigned src_mode  = IDLE_HEAVY;
  int unsigned sink_mode = IDLE_NONE;
  int unsigned bytes_taken = 0;

  always #5 clk = ~clk;

  tlv_record_deframer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  tlvd_record_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_data         (in_ch.data),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_data        (out_ch.data),
    .words_due_count (words_due_count),
    .mismatch_count  (mismatch_count)
  );

  function automatic int unsigned pick_gap(int unsigned mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_HEAVY: return $urandom_range(0, 18);
      default:    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  // Offer one word and return at the edge where it is taken; valid stays high.
  task automatic send_byte(logic [7:0] value, logic first, logic [15:0] blen);
    in_word_t    w;
    int unsigned gap;
    w.data_byte     = value;
    w.buffer_start  = first;
    w.buffer_length = blen;
    gap = pick_gap(src_mode);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Build one buffer of mostly well-formed records and send it.
  task automatic send_buffer();
    logic [7:0]  frame_bytes[$];
    logic [15:0] rtype;
    logic [15:0] rlen;
    logic [15:0] blen;
    logic [15:0] blen_now;
    int unsigned fill;
    int unsigned pick;
    logic        with_start;
    repeat ($urandom_range(1, 4)) begin
      pick  = $urandom_range(0, 99);
      rtype = 16'($urandom);
      if (pick < 10) begin
        rlen = 16'd0;
      end else if (pick < 25) begin
        rtype = quirk_kind;
        rlen  = 16'($urandom_range(0, 5));
      end else if (pick < 80) begin
        rlen = 16'($urandom_range(1, 8));
      end else begin
        rlen = 16'($urandom);
      end
      frame_bytes.push_back(rtype[15:8]);
      frame_bytes.push_back(rtype[7:0]);
      frame_bytes.push_back(rlen[15:8]);
      frame_bytes.push_back(rlen[7:0]);
      // A quirk record with another length is followed by the skipped bytes.
      if (quirk_on && rtype == quirk_kind && rlen != quirk_len) fill = quirk_len;
      else fill = rlen;
      if (fill > 8) fill = $urandom_range(0, 8);
      repeat (fill) frame_bytes.push_back(8'($urandom));
    end
    blen = 16'(frame_bytes.size());
    pick = $urandom_range(0, 99);
    if (pick < 15 && blen > 3) blen = blen - 16'($urandom_range(1, 3));
    else if (pick < 25) blen = 16'($urandom);
    else if (pick < 35) repeat ($urandom_range(1, 2)) frame_bytes.push_back(8'($urandom));
    with_start = ($urandom_range(0, 19) != 0);
    src_mode   = $urandom_range(IDLE_NONE, IDLE_LIGHT);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      blen_now = ($urandom_range(0, 29) == 0) ? 16'($urandom) : blen;
      send_byte(frame_bytes[i], with_start && i == 0, blen_now);
      if (i < blen) bytes_taken++;
    end
  endtask

  // Return once every predicted word has been seen.
  task automatic wait_for_results();
    do @(posedge clk); while (words_due_count != 0);
  endtask

  task automatic write_reg(logic [1:0] index, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Hold the sender until the block is empty, then write every register.
  task automatic apply_setting(logic en, logic [15:0] kind, logic [15:0] len);
    logic [15:0] en_word;
    in_ch.valid <= 1'b0;
    wait_for_results();
    repeat (4) @(posedge clk);
    en_word    = 16'($urandom);
    en_word[0] = en;
    write_reg(CFG_QUIRK_ENABLE, en_word);
    write_reg(CFG_QUIRK_TYPE, kind);
    write_reg(CFG_QUIRK_LENGTH, len);
    write_reg(CFG_UNUSED, 16'($urandom));
    cfg_we     <= 1'b0;
    quirk_on   = en;
    quirk_kind = kind;
    quirk_len  = len;
  endtask

  // Receiving side: stall a random number of cycles before each word.
  initial begin : sink_side
    int unsigned stall;
    out_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_mode = $urandom_range(IDLE_NONE, IDLE_LIGHT);
      stall = pick_gap(sink_mode);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && out_ch.ready)) @(posedge clk);
    end
  end

  // Sending side and verdict.
  initial begin : source_side
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_QUIRK_ENABLE;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 16; i++) send_byte(OPEN_STREAM[127 - 8 * i -: 8], 1'b0, 16'd15);
    for (int i = 0; i < 6; i++) send_byte(OPEN_SHORT[47 - 8 * i -: 8], i == 0, 16'd6);

    // Random buffers under several quirk settings, the extremes among them.
    for (int k = 0; k < 6; k++) begin
      case (k)
        1: apply_setting(1'b1, 16'hFFFF, 16'h0000);
        2: apply_setting(1'b0, 16'h0000, 16'hFFFF);
        3: apply_setting(1'b1, 16'h0000, 16'h0001);
        4: apply_setting(1'b1, 16'($urandom), 16'h0003);
        5: apply_setting(1'b1, QUIRK_TYPE_RST, QUIRK_LENGTH_RST);
        default: ;
      endcase
      while (bytes_taken < (k + 1) * 155) send_buffer();
    end

    in_ch.valid <= 1'b0;
    wait_for_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && words_due_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin : watchdog
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
rtl/tlvd_pkg.sv
rtl/tlvd_stream_if.sv
rtl/tlvd_parser.sv
rtl/tlvd_out_reg.sv
rtl/tlv_record_deframer_unit.sv
tb/tlvd_record_checker.sv
tb/tb_tlv_record_deframer_unit.sv
